// ----- rtl/spd_pkg.sv -----
// Package for the serial packet deframer: shared constants, configuration indices,
// status and field codes, and the packed item types of the input and result channels.
// Depends on nothing; spd_deframe, the top level and the testbench import it.
`timescale 1ns / 1ps

package spd_pkg;

	// Default checksum width and fixed header length in bytes.
	localparam int CRC_BITS_DEF = 16;
	localparam int HEADER_BYTES = 4;

	// Register reset values.
	localparam logic [31:0] TIMEOUT_RESET = 32'd30000;
	localparam logic [15:0] POLY_RESET    = 16'd4129;

	// Framing constants.
	localparam logic [7:0] START_BYTE = 8'h01;
	localparam logic [7:0] SIZE_LIMIT = 8'd128;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POLY    = 1'd1;

	typedef enum logic [2:0] {
		ST_NO_PACKET = 3'd0,
		ST_WAITING   = 3'd1,
		ST_TIMED_OUT = 3'd2,
		ST_RECEIVING = 3'd3,
		ST_RECEIVED  = 3'd4,
		ST_MALFORMED = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		FK_NONE  = 3'd0,
		FK_START = 3'd1,
		FK_SIZE  = 3'd2,
		FK_TYPE  = 3'd3,
		FK_TAG   = 3'd4,
		FK_PARAM = 3'd5
	} field_kind_t;

	typedef struct packed {
		logic        action;
		logic [7:0]  rx_byte;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		status_t     status;
		logic [6:0]  bytes_before;
		field_kind_t field_kind;
		logic [6:0]  param_index;
		logic [7:0]  field_value;
	} out_item_t;

endpackage

// ----- rtl/spd_crc_byte.sv -----
// Byte-wide MSB-first CRC update: folds one byte into the running remainder.
// Depends on nothing but its parameter; used by spd_deframe.
`timescale 1ns / 1ps

module spd_crc_byte #(
	parameter int CRC_BITS = 16
) (
	input  logic [CRC_BITS-1:0] crc,
	input  logic [7:0]          data,
	input  logic [CRC_BITS-1:0] poly,
	output logic [CRC_BITS-1:0] crc_next
);

	always_comb begin
		logic [CRC_BITS-1:0] r;
		r = crc ^ (CRC_BITS'(data) << (CRC_BITS - 8));
		// Eight bit steps, the top bit of the remainder selecting the feedback.
		for (int n = 0; n < 8; n++) begin
			if (r[CRC_BITS-1]) begin
				r = (r << 1) ^ poly;
			end else begin
				r = r << 1;
			end
		end
		crc_next = r;
	end

endmodule

// ----- rtl/spd_deframe.sv -----
// Deframing state and per-item decision logic: byte count, start time, size,
// running and received checksums. Depends on spd_pkg and spd_crc_byte.
`timescale 1ns / 1ps

module spd_deframe #(
	parameter int CRC_BITS = spd_pkg::CRC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  spd_pkg::in_item_t   item,
	input  logic [31:0]         timeout_ms,
	input  logic [CRC_BITS-1:0] crc_poly,
	output spd_pkg::out_item_t  result
);
	import spd_pkg::*;

	localparam int CRC_BYTES = (CRC_BITS + 7) / 8;
	localparam int MIN_SIZE  = HEADER_BYTES + CRC_BYTES;

	logic [6:0]          byte_count_q, byte_count_n;
	logic [31:0]         start_time_q, start_time_n;
	logic [6:0]          packet_size_q, packet_size_n;
	logic [CRC_BITS-1:0] running_crc_q, running_crc_n;
	logic [CRC_BITS-1:0] received_crc_q, received_crc_n;

	logic [31:0]           deadline;
	logic [6:0]            cnt;
	logic [CRC_BITS-1:0]   crc_in;
	logic [CRC_BITS-1:0]   crc_next;
	logic                  crc_take;
	logic [7:0]            pos;
	logic [CRC_BITS+23:0]  byte_shifted;
	logic [CRC_BITS-1:0]   received_ins;

	assign deadline = start_time_q + timeout_ms;
	assign cnt      = byte_count_q + 7'd1;

	// A new packet starts its checksum from zero.
	assign crc_in = (byte_count_q == 7'd0) ? '0 : running_crc_q;

	spd_crc_byte #(
		.CRC_BITS(CRC_BITS)
	) u_crc (
		.crc     (crc_in),
		.data    (item.rx_byte),
		.poly    (crc_poly),
		.crc_next(crc_next)
	);

	// Bytes up to size minus the checksum length feed the CRC; the rest are the
	// little-endian received checksum.
	assign crc_take = ({1'b0, cnt} + 8'(CRC_BYTES)) <= {1'b0, packet_size_q};
	assign pos      = {1'b0, cnt} - ({1'b0, packet_size_q} - 8'(CRC_BYTES)) - 8'd1;
	assign byte_shifted = (CRC_BITS + 24)'(item.rx_byte) << {pos[1:0], 3'b000};
	assign received_ins = (pos < 8'(CRC_BYTES))
		? (received_crc_q | byte_shifted[CRC_BITS-1:0]) : received_crc_q;

	always_comb begin
		byte_count_n   = byte_count_q;
		start_time_n   = start_time_q;
		packet_size_n  = packet_size_q;
		running_crc_n  = running_crc_q;
		received_crc_n = received_crc_q;

		result.status       = ST_NO_PACKET;
		result.bytes_before = byte_count_q;
		result.field_kind   = FK_NONE;
		result.param_index  = 7'd0;
		result.field_value  = 8'd0;

		if (!item.action) begin
			if (byte_count_q != 7'd0) begin
				if (item.now_ms < deadline) begin
					result.status = ST_WAITING;
				end else begin
					result.status = ST_TIMED_OUT;
					byte_count_n  = 7'd0;
				end
			end
		end else if (byte_count_q != 7'd0 && item.now_ms > deadline) begin
			result.status = ST_TIMED_OUT;
			byte_count_n  = 7'd0;
		end else begin
			result.status = ST_RECEIVING;
			if (byte_count_q == 7'd0) begin
				if (item.rx_byte == START_BYTE) begin
					start_time_n       = item.now_ms;
					running_crc_n      = crc_next;
					received_crc_n     = '0;
					result.field_kind  = FK_START;
					result.field_value = item.rx_byte;
					byte_count_n       = cnt;
				end else begin
					byte_count_n  = 7'd0;
					result.status = ST_MALFORMED;
				end
			end else if (byte_count_q == 7'd1) begin
				if (item.rx_byte >= 8'(MIN_SIZE) && item.rx_byte < SIZE_LIMIT) begin
					// The size byte always lies inside the checksummed span.
					packet_size_n      = item.rx_byte[6:0];
					running_crc_n      = crc_next;
					result.field_kind  = FK_SIZE;
					result.field_value = item.rx_byte;
					byte_count_n       = cnt;
				end else begin
					byte_count_n  = 7'd0;
					result.status = ST_MALFORMED;
				end
			end else begin
				if (crc_take) begin
					running_crc_n = crc_next;
				end else begin
					received_crc_n = received_ins;
				end
				result.field_value = item.rx_byte;
				if (cnt == 7'd3) begin
					result.field_kind = FK_TYPE;
				end else if (cnt <= 7'(HEADER_BYTES)) begin
					result.field_kind = FK_TAG;
				end else begin
					result.field_kind  = FK_PARAM;
					result.param_index = cnt - 7'(HEADER_BYTES + 1);
				end
				byte_count_n = cnt;
				if (cnt == packet_size_q) begin
					result.status = (received_crc_n == running_crc_n)
						? ST_RECEIVED : ST_MALFORMED;
					byte_count_n = 7'd0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= 7'd0;
			start_time_q   <= 32'd0;
			packet_size_q  <= 7'd0;
			running_crc_q  <= '0;
			received_crc_q <= '0;
		end else if (step_en) begin
			byte_count_q   <= byte_count_n;
			start_time_q   <= start_time_n;
			packet_size_q  <= packet_size_n;
			running_crc_q  <= running_crc_n;
			received_crc_q <= received_crc_n;
		end
	end

endmodule

// ----- rtl/serial_packet_deframer_crc.sv -----
// Serial packet deframer with CRC check, top level.
// An accepted item is held in the input register; its result is then registered in the
// result register, where it waits until the consumer takes it.
// Throughput: one item per cycle while the consumer takes each result as it comes.
// Reset (arst_n low, asynchronous): both stages empty, framing state zero,
// timeout 30000 ms and polynomial 4129. Depends on spd_pkg and spd_deframe.
`timescale 1ns / 1ps

module serial_packet_deframer_crc #(
	parameter int CRC_BITS = spd_pkg::CRC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,

	input  logic                             in_valid,
	output logic                             in_ready,
	input  spd_pkg::in_item_t                in_item,

	output logic                             out_valid,
	input  logic                             out_ready,
	output spd_pkg::out_item_t               out_item,

	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [spd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [spd_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import spd_pkg::*;

	// Configuration registers. The user must write them only while the block is idle,
	// not enforced by the block; writes are always taken, used directly by the deframer.
	logic [31:0]         timeout_q;
	logic [CRC_BITS-1:0] poly_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
			poly_q    <= CRC_BITS'(POLY_RESET);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TIMEOUT: timeout_q <= cfg_data[31:0];
				CFG_POLY:    poly_q    <= CRC_BITS'(cfg_data[15:0]);
				default:     ;
			endcase
		end
	end

	// Input register. It refills in the same cycle that its item moves on, so a
	// steady stream passes at one item per cycle while the consumer keeps up.
	in_item_t  item_s1;
	logic      valid_s1;
	logic      advance;
	out_item_t result;

	// An item moves from the input register into the result register when the
	// result register is empty or its item is being taken this cycle. The
	// framing state is updated at the same edge.
	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	spd_deframe #(
		.CRC_BITS(CRC_BITS)
	) u_deframe (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (advance),
		.item      (item_s1),
		.timeout_ms(timeout_q),
		.crc_poly  (poly_q),
		.result    (result)
	);

	// Result register. A finished item waits here for the consumer while the
	// input register can still take one more item.
	logic      out_valid_q;
	out_item_t out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

// ----- dv/tb_serial_packet_deframer_crc.sv -----
// Self-checking testbench for serial_packet_deframer_crc: a clocked driver and monitor,
// a cycle-free predictor of the deframer and a queue of expected reports per poll item.
// Depends on spd_pkg and the RTL of the block under test.
`timescale 1ns / 1ps

module tb_serial_packet_deframer_crc;
	import spd_pkg::*;

	// The block is built with its default checksum width, so the predictor works on 16 bits.
	localparam int CRC_BYTES = CRC_BITS_DEF / 8;
	localparam int MIN_SIZE  = HEADER_BYTES + CRC_BYTES;

	logic clk = 1'b0;
	logic arst_n;

	logic                  in_valid;
	logic                  in_ready;
	in_item_t              in_item;
	logic                  out_valid;
	logic                  out_ready;
	out_item_t             out_item;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	serial_packet_deframer_crc uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Register copies, updated when a write is accepted. Both the stimulus generator
	// (to build packets with a correct checksum) and the predictor read them.
	logic [31:0] cfg_timeout = TIMEOUT_RESET;
	logic [15:0] cfg_poly    = POLY_RESET;

	// Predictor state: mirrors the framing state of the deframer.
	logic [6:0]  rx_count = '0;
	logic [31:0] rx_start = '0;
	logic [6:0]  rx_size  = '0;
	logic [15:0] crc_run  = '0;
	logic [15:0] crc_rcvd = '0;

	in_item_t  pending_polls[$];
	out_item_t expected_reports[$];
	int        polls_queued   = 0;
	int        polls_accepted = 0;
	int        mismatches     = 0;

	// Stimulus time base: every queued item carries now_clk, which then advances by a
	// random step of at most time_step milliseconds.
	logic [31:0] now_clk   = '0;
	int          time_step = 0;

	// One byte through an MSB-first CRC, initial value supplied, no final inversion.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b,
			input logic [15:0] poly);
		logic [15:0] r;
		int n;
		r = crc ^ {b, 8'h00};
		for (n = 0; n < 8; n++) begin
			if (r[15])
				r = (r << 1) ^ poly;
			else
				r = r << 1;
		end
		return r;
	endfunction

	// Works out the report for one accepted poll item and advances the framing state.
	function automatic out_item_t predict_frame_status(input in_item_t it);
		out_item_t   r;
		logic [31:0] deadline;
		logic [6:0]  cnt;
		int          pos;
		r.status       = ST_RECEIVING;
		r.bytes_before = rx_count;
		r.field_kind   = FK_NONE;
		r.param_index  = '0;
		r.field_value  = '0;
		deadline = rx_start + cfg_timeout;
		if (!it.action) begin
			// A bare poll only reports progress; at or past the deadline it drops the packet.
			if (rx_count != 0) begin
				if (it.now_ms < deadline) begin
					r.status = ST_WAITING;
				end else begin
					rx_count = '0;
					r.status = ST_TIMED_OUT;
				end
			end else begin
				r.status = ST_NO_PACKET;
			end
		end else if (rx_count != 0 && it.now_ms > deadline) begin
			// A byte is still taken exactly at the deadline, only strictly after it is it lost.
			rx_count = '0;
			r.status = ST_TIMED_OUT;
		end else begin
			cnt = rx_count + 7'd1;
			if (cnt == 7'd1) begin
				if (it.rx_byte == START_BYTE) begin
					rx_start = it.now_ms;
					crc_run  = crc16_byte(16'h0000, it.rx_byte, cfg_poly);
					crc_rcvd = '0;
					r.field_kind  = FK_START;
					r.field_value = it.rx_byte;
					rx_count = cnt;
				end else begin
					rx_count = '0;
					r.status = ST_MALFORMED;
				end
			end else if (cnt == 7'd2) begin
				if (it.rx_byte >= 8'(MIN_SIZE) && it.rx_byte < SIZE_LIMIT) begin
					rx_size = it.rx_byte[6:0];
					if (int'(cnt) + CRC_BYTES <= int'(rx_size))
						crc_run = crc16_byte(crc_run, it.rx_byte, cfg_poly);
					r.field_kind  = FK_SIZE;
					r.field_value = it.rx_byte;
					rx_count = cnt;
				end else begin
					rx_count = '0;
					r.status = ST_MALFORMED;
				end
			end else begin
				// Body bytes feed the running CRC; the trailing bytes build the
				// received checksum, low byte first.
				if (int'(cnt) + CRC_BYTES <= int'(rx_size)) begin
					crc_run = crc16_byte(crc_run, it.rx_byte, cfg_poly);
				end else begin
					pos = int'(cnt) - (int'(rx_size) - CRC_BYTES) - 1;
					if (pos >= 0 && pos < CRC_BYTES)
						crc_rcvd = crc_rcvd | (16'(it.rx_byte) << (8 * pos));
				end
				r.field_value = it.rx_byte;
				if (cnt == 7'd3) begin
					r.field_kind = FK_TYPE;
				end else if (int'(cnt) <= HEADER_BYTES) begin
					r.field_kind = FK_TAG;
				end else begin
					r.field_kind  = FK_PARAM;
					r.param_index = cnt - 7'(HEADER_BYTES) - 7'd1;
				end
				rx_count = cnt;
				if (cnt == rx_size) begin
					if (crc_rcvd == crc_run)
						r.status = ST_RECEIVED;
					else
						r.status = ST_MALFORMED;
					rx_count = '0;
				end
			end
		end
		return r;
	endfunction

	// Length of the next pause on either side: mostly none or short, now and then long.
	// A calm counter gives runs of back-to-back cycles with no pause at all.
	function automatic int pick_pause(ref int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	// Driver: everything changes on the falling edge. The monitor tells it through
	// poll_taken whether the item on the bus was accepted at the last rising edge.
	logic poll_taken = 1'b0;
	int   send_gap   = 0;
	int   send_calm  = 0;
	int   stall_left = 0;
	int   stall_calm = 0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || poll_taken) begin
				if (send_gap > 0) begin
					in_valid <= 1'b0;
					send_gap--;
				end else if (pending_polls.size() != 0) begin
					in_item  <= pending_polls.pop_front();
					in_valid <= 1'b1;
					send_gap = pick_pause(send_calm);
				end else begin
					in_valid <= 1'b0;
				end
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				stall_left = pick_pause(stall_calm);
			end
		end
	end

	// Monitor: samples both handshakes on the rising edge, predicts each accepted item
	// and checks each accepted report against the oldest expectation.
	out_item_t want;

	always @(posedge clk) begin
		if (arst_n) begin
			poll_taken <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				expected_reports.push_back(predict_frame_status(in_item));
				polls_accepted++;
			end
			if (out_valid && out_ready) begin
				if (expected_reports.size() == 0) begin
					$error("report with no item outstanding: status %0d value %0d",
						out_item.status, out_item.field_value);
					mismatches++;
				end else begin
					want = expected_reports.pop_front();
					if (out_item.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, out_item.status);
						mismatches++;
					end
					if (out_item.bytes_before !== want.bytes_before) begin
						$error("bytes_before: expected %0d, got %0d",
							want.bytes_before, out_item.bytes_before);
						mismatches++;
					end
					if (out_item.field_kind !== want.field_kind) begin
						$error("field_kind: expected %0d, got %0d",
							want.field_kind, out_item.field_kind);
						mismatches++;
					end
					if (out_item.param_index !== want.param_index) begin
						$error("param_index: expected %0d, got %0d",
							want.param_index, out_item.param_index);
						mismatches++;
					end
					if (out_item.field_value !== want.field_value) begin
						$error("field_value: expected %0d, got %0d",
							want.field_value, out_item.field_value);
						mismatches++;
					end
				end
			end
		end
	end

	// Queues one poll item at the current stimulus time and moves the time on.
	task automatic queue_item(input logic act, input logic [7:0] b);
		in_item_t it;
		it.action  = act;
		it.rx_byte = b;
		it.now_ms  = now_clk;
		pending_polls.push_back(it);
		polls_queued++;
		now_clk = now_clk + 32'($urandom_range(0, time_step));
	endtask

	// Queues the first keep bytes of a packet of the given size, with a checksum that
	// is correct unless one body or checksum bit is flipped. Bare polls are mixed in.
	task automatic queue_packet(input int size, input logic corrupt, input int keep);
		logic [7:0]  pkt[$];
		logic [15:0] crc;
		int          i;
		int          flip;
		pkt.push_back(START_BYTE);
		pkt.push_back(8'(size));
		for (i = 2; i < size - CRC_BYTES; i++)
			pkt.push_back(8'($urandom_range(0, 255)));
		crc = '0;
		for (i = 0; i < size - CRC_BYTES; i++)
			crc = crc16_byte(crc, pkt[i], cfg_poly);
		pkt.push_back(crc[7:0]);
		pkt.push_back(crc[15:8]);
		if (corrupt) begin
			flip = $urandom_range(2, size - 1);
			pkt[flip] = pkt[flip] ^ (8'd1 << $urandom_range(0, 7));
		end
		for (i = 0; i < keep; i++) begin
			if ($urandom_range(0, 9) == 0)
				queue_item(1'b0, 8'($urandom()));
			queue_item(1'b1, pkt[i]);
		end
	endtask

	// Random traffic: mostly whole packets, some truncated ones and some raw noise.
	// Sizes stay small, with an occasional long packet.
	task automatic queue_random(input int target);
		int first;
		int r;
		int size;
		first = polls_queued;
		while (polls_queued - first < target) begin
			r = $urandom_range(0, 99);
			if ($urandom_range(0, 9) == 0)
				size = $urandom_range(MIN_SIZE, 127);
			else
				size = $urandom_range(MIN_SIZE, MIN_SIZE + 6);
			if (r < 70) begin
				queue_packet(size, $urandom_range(0, 99) < 15, size);
			end else if (r < 80) begin
				queue_packet(size, 1'b0, $urandom_range(1, size - 1));
			end else begin
				repeat ($urandom_range(1, 4))
					queue_item(1'($urandom()), 8'($urandom()));
			end
		end
	endtask

	// Holds the sender off until every queued item has been accepted and reported,
	// then lets the pipeline settle.
	task automatic wait_drained();
		while (polls_accepted != polls_queued || expected_reports.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Register write; only called once the block has drained.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == CFG_TIMEOUT)
			cfg_timeout = val;
		else
			cfg_poly = val[15:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_item   = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_TIMEOUT;
		cfg_data  = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed part with the reset register values and fixed time stamps.
		time_step = 0;
		now_clk = 32'd0;
		queue_item(1'b0, 8'h00);                // poll while idle
		queue_item(1'b1, 8'h00);                // wrong start bytes
		queue_item(1'b1, 8'hFF);
		now_clk = 32'd100;
		queue_packet(MIN_SIZE, 1'b0, MIN_SIZE); // shortest good packet
		queue_item(1'b1, START_BYTE);           // size too small
		queue_item(1'b1, 8'(MIN_SIZE - 1));
		queue_item(1'b1, START_BYTE);           // size with the sign bit set
		queue_item(1'b1, SIZE_LIMIT);
		now_clk = 32'd1000;                     // poll just before, then at, the deadline
		queue_item(1'b1, START_BYTE);
		queue_item(1'b1, 8'd7);
		now_clk = 32'd1000 + TIMEOUT_RESET - 32'd1;
		queue_item(1'b0, 8'h00);
		now_clk = 32'd1000 + TIMEOUT_RESET;
		queue_item(1'b0, 8'h00);
		now_clk = 32'd2000;                     // byte at the deadline, then one after it
		queue_item(1'b1, START_BYTE);
		queue_item(1'b1, 8'(MIN_SIZE));
		now_clk = 32'd2000 + TIMEOUT_RESET;
		queue_item(1'b1, 8'hA5);
		now_clk = now_clk + 32'd1;
		queue_item(1'b1, 8'h5A);
		queue_packet(MIN_SIZE, 1'b1, MIN_SIZE); // checksum mismatch
		now_clk = 32'hFFFF_FFFF;
		queue_item(1'b0, 8'hFF);
		wait_drained();

		// Longest timeout and an all-ones polynomial: the deadline wraps to just
		// before the start time, so most packets time out on their second byte.
		write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
		write_reg(CFG_POLY, {16'($urandom()), 16'hFFFF});
		@(posedge clk);
		time_step = 3;
		queue_random(60);
		wait_drained();

		// Shortest timeout and a zero polynomial.
		write_reg(CFG_TIMEOUT, 32'd1);
		write_reg(CFG_POLY, {16'($urandom()), 16'h0000});
		@(posedge clk);
		time_step = 1;
		queue_random(80);
		wait_drained();

		// Short random timeout and polynomial, with the millisecond clock wrapping.
		write_reg(CFG_TIMEOUT, 32'($urandom_range(20, 200)));
		write_reg(CFG_POLY, $urandom());
		@(posedge clk);
		now_clk = 32'hFFFF_FF00 + 32'($urandom_range(0, 255));
		time_step = 10;
		queue_random(80);
		wait_drained();
		queue_random(80);
		wait_drained();

		// Back to the reset timeout with another polynomial, starting with the
		// longest packet the size field allows.
		write_reg(CFG_TIMEOUT, TIMEOUT_RESET);
		write_reg(CFG_POLY, 32'h0000_8005);
		@(posedge clk);
		now_clk = $urandom();
		time_step = 50;
		queue_packet(127, 1'b0, 127);
		queue_random(40);
		wait_drained();

		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_reports.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/spd_pkg.sv
rtl/spd_crc_byte.sv
rtl/spd_deframe.sv
rtl/serial_packet_deframer_crc.sv
dv/tb_serial_packet_deframer_crc.sv
